FILE: sv/ecint_pkg.sv
// Package for the easing curve interpolator: widths, curve codes and the
// quarter-wave sine table (built at elaboration). No dependencies.
package ecint_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SINE_N    = 256;  // power of two
  localparam int SINE_AW   = $clog2(SINE_N);
  localparam int TURN_W    = SINE_AW + 2;

  localparam int KIND_W  = 3;
  localparam int VAL_W   = 32;
  localparam int PHASE_W = 17;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int W_W     = FRAC_BITS + 1;
  localparam int F_W     = FRAC_BITS;
  localparam int SQ_W    = FRAC_BITS - 1;
  localparam int T_W     = SQ_W + F_W;
  localparam int PROD_W  = DIFF_W + W_W + 1;

  localparam logic [W_W-1:0] ONE  = W_W'(1) << FRAC_BITS;
  localparam logic [W_W-1:0] HALF = W_W'(1) << (FRAC_BITS - 1);

  localparam logic [32:0] ONE_Q30 = 33'(1) << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [KIND_W-1:0] {
    K_LINEAR   = 3'd0,
    K_PINGPONG = 3'd1,
    K_SQUARED  = 3'd2,
    K_SINE     = 3'd3,
    K_COSINE   = 3'd4,
    K_CUBIC    = 3'd5
  } kind_t;

  typedef logic [31:0] qw_arr_t [0:SINE_N];

  // restoring long division, only evaluated while the table is built
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin over [0, pi/2] in Q2.30, integer Taylor series of thirteen terms
  function automatic qw_arr_t build_qw();
    qw_arr_t tbl;
    longint unsigned x;
    longint unsigned term;
    longint unsigned den;
    longint sum;
    for (int k = 0; k <= SINE_N; k++) begin
      x    = (HALF_PI_Q30 * longint'(k) + longint'(SINE_N / 2)) >> SINE_AW;
      sum  = longint'(x);
      term = x;
      for (int n = 1; n <= 12; n++) begin
        den  = longint'((2 * n) * (2 * n + 1));
        term = (term * x) >> 30;
        term = div_u64((term * x) >> 30, den);
        if ((n % 2) == 1) sum = sum - longint'(term);
        else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
      tbl[k] = 32'(sum);
    end
    return tbl;
  endfunction

  localparam qw_arr_t QW = build_qw();

endpackage

FILE: sv/ecint_shape.sv
// Weight pipeline: phase fold, sine lookup, squares and cube, curve select.
// Four register stages; depends on ecint_pkg.
module ecint_shape (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [ecint_pkg::KIND_W-1:0]        kind,
  input  logic signed [ecint_pkg::VAL_W-1:0]  from_val,
  input  logic signed [ecint_pkg::VAL_W-1:0]  to_val,
  input  logic [ecint_pkg::PHASE_W-1:0]       phase,
  output logic                                w_valid,
  output logic [ecint_pkg::W_W-1:0]           weight,
  output logic signed [ecint_pkg::VAL_W-1:0]  base,
  output logic signed [ecint_pkg::DIFF_W-1:0] span
);
  import ecint_pkg::*;

  localparam int IDX_PW = PHASE_W + TURN_W + FRAC_BITS + 1;

  // stage 1
  logic [W_W-1:0] p_sat, p1_r;
  logic [F_W-1:0] f_nxt, f1_r;
  logic lo_nxt, lo1_r;
  logic [IDX_PW-1:0] idx_sum;
  logic [TURN_W-1:0] turn_nxt, turn1_r;
  logic signed [DIFF_W-1:0] diff_nxt, diff1_r;
  logic signed [VAL_W-1:0] a1_r;
  kind_t kind1_r;
  logic v1_r;

  always_comb begin
    p_sat   = (W_W'(phase) > ONE) ? ONE : W_W'(phase);
    lo_nxt  = p_sat < HALF;
    f_nxt   = lo_nxt ? F_W'(p_sat) : F_W'(ONE - p_sat);
    idx_sum = ((IDX_PW'(p_sat) << TURN_W) + IDX_PW'(HALF)) >> FRAC_BITS;
    turn_nxt = idx_sum[TURN_W-1:0];
    diff_nxt = DIFF_W'(to_val) - DIFF_W'(from_val);
  end

  // stage 2
  logic [TURN_W-1:0] turn_k;
  logic [1:0] quad;
  logic [SINE_AW:0] qidx;
  logic [32:0] sin_v;
  logic [32:0] sin_sum;
  logic [W_W-1:0] wsin_nxt, wsin2_r;
  logic [2*F_W-1:0] ff_nxt, ff2_r;
  logic [W_W-1:0] p2_r;
  logic [F_W-1:0] f2_r;
  logic lo2_r;
  logic signed [DIFF_W-1:0] diff2_r;
  logic signed [VAL_W-1:0] a2_r;
  kind_t kind2_r;
  logic v2_r;

  always_comb begin
    turn_k  = (kind1_r == K_COSINE) ? turn1_r + TURN_W'(SINE_N) : turn1_r;
    quad    = turn_k[TURN_W-1 -: 2];
    qidx    = quad[0] ? (SINE_AW+1)'(SINE_N) - {1'b0, turn_k[SINE_AW-1:0]}
                      : {1'b0, turn_k[SINE_AW-1:0]};
    sin_v   = quad[1] ? ONE_Q30 - 33'(QW[qidx]) : ONE_Q30 + 33'(QW[qidx]);
    sin_sum = (sin_v + (33'(1) << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
    wsin_nxt = sin_sum[W_W-1:0];
    ff_nxt  = (2*F_W)'(f1_r) * (2*F_W)'(f1_r);
  end

  // stage 3
  logic [2*F_W+2:0] sq_sum, wsq_sum;
  logic [SQ_W-1:0] sq;
  logic [W_W-1:0] wsq_nxt, wsq3_r, wsin3_r, p3_r;
  logic [T_W-1:0] t_nxt, t3_r;
  logic [F_W-1:0] f3_r;
  logic lo3_r;
  logic signed [DIFF_W-1:0] diff3_r;
  logic signed [VAL_W-1:0] a3_r;
  kind_t kind3_r;
  logic v3_r;

  always_comb begin
    sq_sum  = ((2*F_W+3)'(ff2_r) + (2*F_W+3)'(HALF)) >> FRAC_BITS;
    sq      = sq_sum[SQ_W-1:0];
    wsq_sum = (((2*F_W+3)'(ff2_r) << 2) + (2*F_W+3)'(HALF)) >> FRAC_BITS;
    wsq_nxt = wsq_sum[W_W-1:0];
    t_nxt   = T_W'(sq) * T_W'(f2_r);
  end

  // stage 4
  logic [T_W+2:0] cube_sum;
  logic [W_W-1:0] cube, w_nxt, w4_r;
  logic signed [DIFF_W-1:0] diff4_r;
  logic signed [VAL_W-1:0] a4_r;
  logic v4_r;

  always_comb begin
    cube_sum = (((T_W+3)'(t3_r) << 2) + (T_W+3)'(HALF)) >> FRAC_BITS;
    cube     = cube_sum[W_W-1:0];
    case (kind3_r)
      K_PINGPONG:       w_nxt = W_W'(f3_r) << 1;
      K_SQUARED:        w_nxt = wsq3_r;
      K_SINE, K_COSINE: w_nxt = wsin3_r;
      K_CUBIC:          w_nxt = lo3_r ? cube : ONE - cube;
      default:          w_nxt = p3_r;  // linear, and unknown codes
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p_sat;
      f1_r    <= f_nxt;
      lo1_r   <= lo_nxt;
      turn1_r <= turn_nxt;
      diff1_r <= diff_nxt;
      a1_r    <= from_val;
      kind1_r <= kind_t'(kind);

      wsin2_r <= wsin_nxt;
      ff2_r   <= ff_nxt;
      p2_r    <= p1_r;
      f2_r    <= f1_r;
      lo2_r   <= lo1_r;
      diff2_r <= diff1_r;
      a2_r    <= a1_r;
      kind2_r <= kind1_r;

      wsq3_r  <= wsq_nxt;
      wsin3_r <= wsin2_r;
      t3_r    <= t_nxt;
      p3_r    <= p2_r;
      f3_r    <= f2_r;
      lo3_r   <= lo2_r;
      diff3_r <= diff2_r;
      a3_r    <= a2_r;
      kind3_r <= kind2_r;

      w4_r    <= w_nxt;
      diff4_r <= diff3_r;
      a4_r    <= a3_r;
    end
  end

  assign w_valid = v4_r;
  assign weight  = w4_r;
  assign base    = a4_r;
  assign span    = diff4_r;

endmodule

FILE: sv/ecint_blend.sv
// Blend pipeline: span times weight, round half away from zero, add to base.
// Three register stages, the last one is the output register; uses ecint_pkg.
module ecint_blend (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                w_valid,
  input  logic [ecint_pkg::W_W-1:0]           weight,
  input  logic signed [ecint_pkg::VAL_W-1:0]  base,
  input  logic signed [ecint_pkg::DIFF_W-1:0] span,
  output logic                                res_valid,
  output logic signed [ecint_pkg::VAL_W-1:0]  result
);
  import ecint_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt, prod5_r;
  logic signed [VAL_W-1:0] a5_r, a6_r;
  logic v5_r, v6_r, vo_r;

  logic [PROD_W-1:0] mag;
  logic [PROD_W-1:0] mag_rnd;
  logic [DIFF_W-1:0] r_nxt, r6_r;
  logic neg_nxt, neg6_r;

  logic signed [DIFF_W-1:0] res_nxt;
  logic signed [VAL_W-1:0] res_r;

  always_comb begin
    prod_nxt = PROD_W'(span) * $signed({1'b0, weight});
    neg_nxt  = prod5_r[PROD_W-1];
    mag      = neg_nxt ? PROD_W'(-prod5_r) : PROD_W'(prod5_r);
    mag_rnd  = (mag + PROD_W'(HALF)) >> FRAC_BITS;
    r_nxt    = mag_rnd[DIFF_W-1:0];
    res_nxt  = neg6_r ? DIFF_W'(a6_r) - $signed(r6_r) : DIFF_W'(a6_r) + $signed(r6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v5_r <= w_valid;
      v6_r <= v5_r;
      vo_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod5_r <= prod_nxt;
      a5_r    <= base;
      r6_r    <= r_nxt;
      neg6_r  <= neg_nxt;
      a6_r    <= a5_r;
      res_r   <= res_nxt[VAL_W-1:0];
    end
  end

  assign res_valid = vo_r;
  assign result    = res_r;

endmodule

FILE: sv/easing_curve_interpolator.sv
// Easing curve interpolator top level: handshake control around the weight
// and blend pipelines. Depends on ecint_pkg, ecint_shape and ecint_blend.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat carries a curve code, a start
//   and an end value (signed Q16.16) and a phase (Q1.16, above 1.0 clamps).
//   Codes: linear, ping-pong, squared ping-pong, sine, cosine, cubic ease;
//   unused codes act as linear.
//   Output channel (out_valid/out_ready): one beat per input beat, in order,
//   carrying the eased value between start and end.
//   Throughput: one beat per cycle; the seven-stage pipeline takes a new
//   beat every cycle while the output register is empty or being drained.
//   Stall: when out_valid is high and out_ready low, the whole pipeline
//   holds and in_ready drops in the same cycle; nothing is lost or repeated.
//   Reset: synchronous, active low; all stage valid bits clear, so the
//   pipeline comes up empty. The sine table is a constant, no fill needed.
module easing_curve_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ecint_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [ecint_pkg::VAL_W-1:0]  in_from_val,
  input  logic signed [ecint_pkg::VAL_W-1:0]  in_to_val,
  input  logic [ecint_pkg::PHASE_W-1:0]       in_phase,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ecint_pkg::VAL_W-1:0]  out_interpolated
);
  import ecint_pkg::*;

  logic en;
  logic w_valid;
  logic [W_W-1:0] weight;
  logic signed [VAL_W-1:0] base;
  logic signed [DIFF_W-1:0] span;

  // advance every stage unless a finished beat sits unclaimed at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ecint_shape u_shape (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .kind        (in_kind),
    .from_val    (in_from_val),
    .to_val      (in_to_val),
    .phase       (in_phase),
    .w_valid     (w_valid),
    .weight      (weight),
    .base        (base),
    .span        (span)
  );

  ecint_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .w_valid   (w_valid),
    .weight    (weight),
    .base      (base),
    .span      (span),
    .res_valid (out_valid),
    .result    (out_interpolated)
  );

`ifndef SYNTHESIS
  // a shaped weight never exceeds 1.0
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid |-> weight <= ONE)
    else $error("weight above one");

  // a held pipeline keeps its weight stage intact
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && w_valid) |=> (w_valid && $stable(weight) && $stable(span)))
    else $error("weight stage changed during stall");

  // reset leaves the output empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
